// File: design/rbst_pkg.sv
package rbst_pkg;

    localparam int COORD_W   = 24;
    localparam int DIST_W    = 32;
    localparam int DIST_FRAC = DIST_W / 2;
    localparam int EPS_W     = DIST_W - 1;
    localparam int EPS_RESET = 66;
    localparam int LANES     = 3;
    localparam int FIELDS    = 4 * LANES;
    localparam int V_W       = COORD_W + 1;
    localparam int N_W       = V_W + DIST_FRAC;
    localparam int Q_W       = DIST_W - 1;
    localparam int R_W       = COORD_W + 1;
    localparam int CMP_W     = COORD_W + Q_W + 1;
    localparam int LANE_LAT  = Q_W + 2;
    localparam int IN_W      = ((FIELDS * COORD_W + 7) / 8) * 8;
    localparam int OUT_W     = 8;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIST_W-1:0]  t_dist;

    localparam t_dist DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
    localparam t_dist DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};

    typedef struct packed {
        logic  miss;
        t_dist near_t;
        t_dist far_t;
    } t_lane_res;

endpackage

// File: design/ray_box_slab_test.sv
// Channel   Direction  Handshake                  Payload
// s stream  in         i_s_tvalid / o_s_tready    i_s_tdata: box, ray (12 x 24 bits)
// m stream  out        o_m_tvalid / i_m_tready    o_m_tdata: hit
// config    in         i_cfg_we                   i_cfg_wdata: exit_epsilon
//
// One transaction is accepted every cycle while the output can move.
// Data passes through the 31-stage radix-2 dividers in each axis lane and then through
// the lane, merge and output registers.
// Reset (synchronous, active low) clears the valid pipeline and loads exit_epsilon with 66.
// A stall at the output freezes the whole pipeline, so no result is lost.
module ray_box_slab_test (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // From bit 0 up: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
    // box_max_z, ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x,
    // ray_dir_y, ray_dir_z, 24 bits each.
    input  logic [rbst_pkg::IN_W-1:0]       i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // From bit 0 up: hit, then seven zero bits.
    output logic [rbst_pkg::OUT_W-1:0]      o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [rbst_pkg::EPS_W-1:0]      i_cfg_wdata
);

    logic                            n_ce;
    logic [rbst_pkg::LANE_LAT:0]     r_vld;
    logic                            r_out_valid;
    logic                            r_hit;
    logic                            n_hit;
    logic [rbst_pkg::EPS_W-1:0]      r_eps;
    rbst_pkg::t_lane_res             n_res [rbst_pkg::LANES];

    // The pipeline advances whenever the output register is free or being drained.
    assign n_ce       = !r_out_valid || i_m_tready;
    assign o_s_tready = n_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= rbst_pkg::EPS_W'(rbst_pkg::EPS_RESET);
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // Lane a handles axis a: fields a (min), 3+a (max), 6+a (origin), 9+a (direction).
    for (genvar a = 0; a < rbst_pkg::LANES; a++) begin : g_lane
        rbst_lane u_lane (
            .i_clk (i_clk),
            .i_en  (n_ce),
            .i_lo  (i_s_tdata[a * rbst_pkg::COORD_W +: rbst_pkg::COORD_W]),
            .i_hi  (i_s_tdata[(rbst_pkg::LANES + a) * rbst_pkg::COORD_W +: rbst_pkg::COORD_W]),
            .i_org (i_s_tdata[(2 * rbst_pkg::LANES + a) * rbst_pkg::COORD_W +:
                              rbst_pkg::COORD_W]),
            .i_dir (i_s_tdata[(3 * rbst_pkg::LANES + a) * rbst_pkg::COORD_W +:
                              rbst_pkg::COORD_W]),
            .o_res (n_res[a])
        );
    end

    rbst_merge u_merge (
        .i_clk (i_clk),
        .i_en  (n_ce),
        .i_res (n_res),
        .i_eps (r_eps),
        .o_hit (n_hit)
    );

    // Valid bits follow the data through the lane and merge registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (n_ce) begin
            r_vld       <= {r_vld[rbst_pkg::LANE_LAT-1:0], i_s_tvalid};
            r_out_valid <= r_vld[rbst_pkg::LANE_LAT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_ce) begin
            r_hit <= n_hit;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = rbst_pkg::OUT_W'(r_hit);

endmodule

// File: design/rbst_divider.sv
module rbst_divider (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [rbst_pkg::V_W-1:0]         i_mag_v,
    input  logic [rbst_pkg::COORD_W-1:0]     i_mag_d,
    output logic [rbst_pkg::Q_W-1:0]         o_quot
);

    // One quotient bit per stage; the caller flags quotients that would overflow.
    logic [rbst_pkg::R_W-1:0]     r_rem  [0:rbst_pkg::Q_W];
    logic [rbst_pkg::N_W-1:0]     r_num  [0:rbst_pkg::Q_W];
    logic [rbst_pkg::COORD_W-1:0] r_den  [0:rbst_pkg::Q_W];
    logic [rbst_pkg::Q_W-1:0]     r_quot [0:rbst_pkg::Q_W];
    logic [rbst_pkg::N_W-1:0]     n_num;

    assign n_num = {i_mag_v, {rbst_pkg::DIST_FRAC{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0]  <= n_num;
            r_rem[0]  <= rbst_pkg::R_W'(n_num >> rbst_pkg::Q_W);
            r_den[0]  <= i_mag_d;
            r_quot[0] <= '0;
        end
    end

    for (genvar s = 0; s < rbst_pkg::Q_W; s++) begin : g_stage
        logic [rbst_pkg::R_W-1:0] n_trial;
        logic                     n_ge;

        assign n_trial = {r_rem[s][rbst_pkg::R_W-2:0], r_num[s][rbst_pkg::Q_W-1-s]};
        assign n_ge    = (n_trial >= {1'b0, r_den[s]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= n_ge ? (n_trial - {1'b0, r_den[s]}) : n_trial;
                r_num[s+1]  <= r_num[s];
                r_den[s+1]  <= r_den[s];
                r_quot[s+1] <= {r_quot[s][rbst_pkg::Q_W-2:0], n_ge};
            end
        end
    end

    assign o_quot = r_quot[rbst_pkg::Q_W];

endmodule

// File: design/rbst_lane.sv
module rbst_lane (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  rbst_pkg::t_coord     i_lo,
    input  rbst_pkg::t_coord     i_hi,
    input  rbst_pkg::t_coord     i_org,
    input  rbst_pkg::t_coord     i_dir,
    output rbst_pkg::t_lane_res  o_res
);

    typedef struct packed {
        logic zero;
        logic miss;
        logic neg1;
        logic sat1;
        logic neg2;
        logic sat2;
    } t_flags;

    logic signed [rbst_pkg::V_W-1:0]   n_v1, n_v2;
    logic [rbst_pkg::V_W-1:0]          n_mv1, n_mv2;
    logic [rbst_pkg::COORD_W-1:0]      n_md;
    logic [rbst_pkg::CMP_W-1:0]        n_den_sh;
    t_flags                            n_flags;
    t_flags                            r_flags [0:rbst_pkg::Q_W];
    logic [rbst_pkg::Q_W-1:0]          n_q1, n_q2;
    rbst_pkg::t_dist                   n_t1, n_t2;
    rbst_pkg::t_lane_res               r_res;

    always_comb begin
        n_v1  = $signed({i_lo[rbst_pkg::COORD_W-1], i_lo}) -
                $signed({i_org[rbst_pkg::COORD_W-1], i_org});
        n_v2  = $signed({i_hi[rbst_pkg::COORD_W-1], i_hi}) -
                $signed({i_org[rbst_pkg::COORD_W-1], i_org});
        n_mv1 = n_v1[rbst_pkg::V_W-1] ? rbst_pkg::V_W'(-n_v1) : n_v1;
        n_mv2 = n_v2[rbst_pkg::V_W-1] ? rbst_pkg::V_W'(-n_v2) : n_v2;
        n_md  = i_dir[rbst_pkg::COORD_W-1] ? rbst_pkg::COORD_W'(-i_dir) : i_dir;
        n_den_sh = rbst_pkg::CMP_W'(n_md) << rbst_pkg::Q_W;
        n_flags.zero = (i_dir == '0);
        n_flags.miss = (i_dir == '0) && ((i_org < i_lo) || (i_org > i_hi));
        n_flags.neg1 = n_v1[rbst_pkg::V_W-1] ^ i_dir[rbst_pkg::COORD_W-1];
        n_flags.neg2 = n_v2[rbst_pkg::V_W-1] ^ i_dir[rbst_pkg::COORD_W-1];
        n_flags.sat1 = rbst_pkg::CMP_W'({n_mv1, {rbst_pkg::DIST_FRAC{1'b0}}}) >= n_den_sh;
        n_flags.sat2 = rbst_pkg::CMP_W'({n_mv2, {rbst_pkg::DIST_FRAC{1'b0}}}) >= n_den_sh;
    end

    rbst_divider u_div1 (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_mag_v (n_mv1),
        .i_mag_d (n_md),
        .o_quot  (n_q1)
    );

    rbst_divider u_div2 (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_mag_v (n_mv2),
        .i_mag_d (n_md),
        .o_quot  (n_q2)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags[0] <= n_flags;
        end
    end

    for (genvar s = 0; s < rbst_pkg::Q_W; s++) begin : g_flag
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flags[s+1] <= r_flags[s];
            end
        end
    end

    // A parallel axis with the origin inside its slab bounds nothing.
    always_comb begin
        t_flags f;
        f = r_flags[rbst_pkg::Q_W];
        if (f.sat1) begin
            n_t1 = f.neg1 ? rbst_pkg::DIST_MIN : rbst_pkg::DIST_MAX;
        end else if (f.neg1) begin
            n_t1 = -$signed(rbst_pkg::DIST_W'({1'b0, n_q1}));
        end else begin
            n_t1 = rbst_pkg::DIST_W'({1'b0, n_q1});
        end
        if (f.sat2) begin
            n_t2 = f.neg2 ? rbst_pkg::DIST_MIN : rbst_pkg::DIST_MAX;
        end else if (f.neg2) begin
            n_t2 = -$signed(rbst_pkg::DIST_W'({1'b0, n_q2}));
        end else begin
            n_t2 = rbst_pkg::DIST_W'({1'b0, n_q2});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.miss <= r_flags[rbst_pkg::Q_W].miss;
            if (r_flags[rbst_pkg::Q_W].zero) begin
                r_res.near_t <= rbst_pkg::DIST_MIN;
                r_res.far_t  <= rbst_pkg::DIST_MAX;
            end else begin
                r_res.near_t <= (n_t1 < n_t2) ? n_t1 : n_t2;
                r_res.far_t  <= (n_t1 < n_t2) ? n_t2 : n_t1;
            end
        end
    end

    assign o_res = r_res;

endmodule

// File: design/rbst_merge.sv
module rbst_merge (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  rbst_pkg::t_lane_res       i_res [rbst_pkg::LANES],
    input  logic [rbst_pkg::EPS_W-1:0] i_eps,
    output logic                      o_hit
);

    rbst_pkg::t_dist r_tmin, r_tmax;
    logic            r_miss;
    rbst_pkg::t_dist n_tmin, n_tmax;
    logic            n_miss;

    always_comb begin
        n_tmin = rbst_pkg::DIST_MIN;
        n_tmax = rbst_pkg::DIST_MAX;
        n_miss = 1'b0;
        for (int i = 0; i < rbst_pkg::LANES; i++) begin
            if (i_res[i].near_t > n_tmin) n_tmin = i_res[i].near_t;
            if (i_res[i].far_t < n_tmax)  n_tmax = i_res[i].far_t;
            n_miss = n_miss | i_res[i].miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tmin <= n_tmin;
            r_tmax <= n_tmax;
            r_miss <= n_miss;
        end
    end

    assign o_hit = !r_miss && (r_tmin <= r_tmax) &&
                   ($signed({r_tmax[rbst_pkg::DIST_W-1], r_tmax}) >=
                    $signed({2'b00, i_eps}));

endmodule

// File: design/rbst_checker.sv
module rbst_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [rbst_pkg::OUT_W-1:0]  o_m_tdata
);

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while the output register is empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output transaction changed or dropped");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[rbst_pkg::OUT_W-1:1] == '0)
        else $error("output padding bits are not zero");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
